@@ rtl/pem_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Prewitt edge magnitude block.
package pem_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int PIX_W     = 8;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(300);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
    localparam logic [1:0]         ROWS_FULL   = 2'd2;
    localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;

    // Index order: 0..2 top row, 3..5 middle row, 6..8 bottom row, left to right.
    typedef logic [8:0][PIX_W-1:0] window_t;

    // Pixel held in the address stage while its line buffer read completes.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        pix_t              pixel;
        logic              emit;
        logic              row_end;
    } pem_item_t;

    // Status of the window stage as seen by the result stage.
    typedef struct packed {
        logic valid;
        logic emit;
        logic row_end;
    } pem_stage_t;

    // Sum of three pixels.
    function automatic logic [9:0] sum3(input pix_t a, input pix_t b, input pix_t c);
        return {2'b00, a} + {2'b00, b} + {2'b00, c};
    endfunction

    // |a - b| clamped to the pixel range.
    function automatic pix_t clamp_abs_diff(input logic [9:0] a, input logic [9:0] b);
        logic [9:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (d > {2'b00, PIX_MAX}) ? PIX_MAX : d[PIX_W-1:0];
    endfunction

endpackage

@@ rtl/pem_scan.sv @@
// Width register, raster position tracking and the address stage register.
module pem_scan import pem_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WIDTH_W-1:0]  image_width,
    input  logic                in_valid,
    output logic                in_ready,
    input  pix_t                pixel,
    input  logic                frame_start,
    input  logic                a_adv,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    output logic                a_valid,
    output pem_item_t           a_item
);

    logic [WIDTH_W-1:0] width_reg;
    logic [ADDR_W-1:0]  col_reg, col_next;
    logic [1:0]         rows_reg, rows_next;
    logic               a_valid_reg, a_valid_next;
    pem_item_t          a_item_reg;

    logic [WIDTH_W-1:0] w_eff;
    logic [ADDR_W-1:0]  col0, c;
    logic [1:0]         rows0, r;
    logic               wrap, last, accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !a_valid_reg || a_adv;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            w_eff = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = width_reg;

        col0  = frame_start ? '0 : col_reg;
        rows0 = frame_start ? '0 : rows_reg;

        // A width shrunk mid-row sends the pixel to the start of the next row.
        wrap = {1'b0, col0} >= w_eff;
        c    = wrap ? '0 : col0;
        if (wrap && rows0 != ROWS_FULL)
            r = rows0 + 2'd1;
        else
            r = rows0;

        last = ({1'b0, c} + WIDTH_W'(1)) >= w_eff;
        if (last)
        begin
            col_next  = '0;
            rows_next = (r != ROWS_FULL) ? r + 2'd1 : r;
        end
        else
        begin
            col_next  = c + ADDR_W'(1);
            rows_next = r;
        end

        a_valid_next = accept || (a_valid_reg && !a_adv);
    end

    assign rd_en   = accept;
    assign rd_addr = c;
    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            col_reg     <= '0;
            rows_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_reg <= image_width;
            if (accept)
            begin
                col_reg  <= col_next;
                rows_reg <= rows_next;
            end
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg.addr    <= c;
            a_item_reg.pixel   <= pixel;
            a_item_reg.emit    <= (r == ROWS_FULL) && (c >= ADDR_W'(2));
            a_item_reg.row_end <= ({1'b0, c} == (w_eff - WIDTH_W'(1)));
        end
    end

endmodule

@@ rtl/pem_window.sv @@
// Two line buffers with write-to-read forwarding and the 3x3 window stage.
module pem_window import pem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              a_valid,
    input  pem_item_t         a_item,
    output logic              a_adv,
    input  logic              out_free,
    output pem_stage_t        b_stat,
    output window_t           win
);

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    pix_t    upper_rd_reg, middle_rd_reg;
    pix_t    fwd_upper_reg, fwd_middle_reg;
    logic    hit_reg;
    window_t win_reg;
    logic    b_valid_reg, b_emit_reg, b_row_end_reg;

    pix_t up_eff, mid_eff;
    logic b_leave;

    assign up_eff  = hit_reg ? fwd_upper_reg  : upper_rd_reg;
    assign mid_eff = hit_reg ? fwd_middle_reg : middle_rd_reg;

    assign b_leave = !b_emit_reg || out_free;
    assign a_adv   = a_valid && (!b_valid_reg || b_leave);

    // A read that hits the entry being written in the same cycle takes the new data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hit_reg        <= a_adv && (rd_addr == a_item.addr);
            fwd_upper_reg  <= mid_eff;
            fwd_middle_reg <= a_item.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            upper_rd_reg <= upper_mem[rd_addr];
        if (a_adv)
            upper_mem[a_item.addr] <= mid_eff;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            middle_rd_reg <= middle_mem[rd_addr];
        if (a_adv)
            middle_mem[a_item.addr] <= a_item.pixel;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= up_eff;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid_eff;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= a_item.pixel;
            b_emit_reg    <= a_item.emit;
            b_row_end_reg <= a_item.row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (a_adv)
            b_valid_reg <= 1'b1;
        else if (b_leave)
            b_valid_reg <= 1'b0;
    end

    assign b_stat.valid   = b_valid_reg;
    assign b_stat.emit    = b_emit_reg;
    assign b_stat.row_end = b_row_end_reg;
    assign win            = win_reg;

endmodule

@@ rtl/pem_gradient.sv @@
// Prewitt gradient arithmetic and the result register.
module pem_gradient import pem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pem_stage_t b_stat,
    input  window_t    win,
    output logic       out_free,
    output logic       out_valid,
    input  logic       out_ready,
    output pix_t       row_gradient,
    output pix_t       column_gradient,
    output pix_t       magnitude,
    output logic       row_end
);

    logic       out_valid_reg;
    pix_t       row_grad_reg, col_grad_reg, mag_reg;
    logic       row_end_reg;

    logic [9:0] top, bot, lft, rgt;
    pix_t       rg, cg;
    logic [8:0] msum;
    pix_t       mag_next;
    logic       load;

    always_comb
    begin
        top  = sum3(win[0], win[1], win[2]);
        bot  = sum3(win[6], win[7], win[8]);
        lft  = sum3(win[0], win[3], win[6]);
        rgt  = sum3(win[2], win[5], win[8]);
        rg   = clamp_abs_diff(bot, top);
        cg   = clamp_abs_diff(rgt, lft);
        msum = {1'b0, rg} + {1'b0, cg};
        mag_next = msum[8] ? PIX_MAX : msum[7:0];
    end

    assign out_free = !out_valid_reg || out_ready;
    assign load     = b_stat.valid && b_stat.emit && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_grad_reg <= rg;
            col_grad_reg <= cg;
            mag_reg      <= mag_next;
            row_end_reg  <= b_stat.row_end;
        end
    end

    assign out_valid       = out_valid_reg;
    assign row_gradient    = row_grad_reg;
    assign column_gradient = col_grad_reg;
    assign magnitude       = mag_reg;
    assign row_end         = row_end_reg;

endmodule

@@ rtl/prewitt_edge_magnitude.sv @@
// Top level of the 3x3 Prewitt edge magnitude block on a raster pixel stream.
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------------
//  config    cfg_valid/cfg_ready    image_width
//  input     in_valid/in_ready      pixel, frame_start
//  result    out_valid/out_ready    row_gradient, column_gradient, magnitude, row_end
//
// One pixel is accepted per cycle unless the pipeline stalls. A pixel passes an
// address stage (line buffer read), a window stage and the result register. The
// line buffers are single read, single write memories. Reset clears position and
// valid flags and loads the default width only; the line buffers need no clearing
// pass. A stalled result stops the pipeline only when a result is waiting.
module prewitt_edge_magnitude import pem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] image_width,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         pixel,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         row_gradient,
    output logic [7:0]         column_gradient,
    output logic [7:0]         magnitude,
    output logic               row_end
);

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              a_valid, a_adv;
    pem_item_t         a_item;
    pem_stage_t        b_stat;
    window_t           win;
    logic              out_free;

    pem_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .image_width (image_width),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .a_adv       (a_adv),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .a_valid     (a_valid),
        .a_item      (a_item)
    );

    pem_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .a_valid  (a_valid),
        .a_item   (a_item),
        .a_adv    (a_adv),
        .out_free (out_free),
        .b_stat   (b_stat),
        .win      (win)
    );

    pem_gradient u_gradient (
        .clk             (clk),
        .rst_n           (rst_n),
        .b_stat          (b_stat),
        .win             (win),
        .out_free        (out_free),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_gradient    (row_gradient),
        .column_gradient (column_gradient),
        .magnitude       (magnitude),
        .row_end         (row_end)
    );

endmodule

@@ tb/prewitt_edge_magnitude_tb.sv @@
// Self-checking testbench for the Prewitt edge magnitude block with a local predictor.
module prewitt_edge_magnitude_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pem_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 6;
    localparam int END_SETTLE   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_LIGHT   = 37;
    localparam int IDLE_HEAVY   = 88;
    localparam int IDLE_NONE    = 0;

    typedef struct packed {
        pix_t row_grad;
        pix_t col_grad;
        pix_t mag;
        logic row_end;
    } edge_result_t;

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } pixel_req_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [WIDTH_W-1:0] cfg_width   = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    pix_t               pixel       = '0;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    pix_t               row_gradient;
    pix_t               column_gradient;
    pix_t               magnitude;
    logic               row_end;

    prewitt_edge_magnitude dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .image_width     (cfg_width),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel           (pixel),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_gradient    (row_gradient),
        .column_gradient (column_gradient),
        .magnitude       (magnitude),
        .row_end         (row_end)
    );

    always #5 clk = ~clk;

    // Predictor state: line stores, window, raster position and the width in force.
    pix_t               upper_row    [MAX_WIDTH];
    pix_t               middle_row   [MAX_WIDTH];
    bit                 upper_known  [MAX_WIDTH];
    bit                 middle_known [MAX_WIDTH];
    pix_t               win          [9] = '{default: '0};
    bit                 win_known    [9] = '{default: 1'b1};
    int unsigned        next_col      = 0;
    int unsigned        full_rows     = 0;
    logic [WIDTH_W-1:0] width_setting = WIDTH_RESET;

    pixel_req_t   pixel_queue[$];
    edge_result_t expected_edges[$];
    pixel_req_t   next_req;
    edge_result_t oldest_edge;

    int queued_count      = 0;
    int accepted_count    = 0;
    int results_checked   = 0;
    int row_end_count     = 0;
    int wide_results      = 0;
    int shrink_wraps      = 0;
    int config_writes     = 0;
    int failures          = 0;
    int cycle_count       = 0;
    int sender_idle_pct   = IDLE_LIGHT;
    int receiver_idle_pct = IDLE_HEAVY;

    // Random stream shaping: rows per frame and the kind of picture content.
    int frame_rows = 0;
    int rows_goal  = 3;
    int style      = 0;
    int level      = 128;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_setting;
        if (w < WIDTH_MIN)
            w = WIDTH_MIN;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic pix_t clip_abs(int g);
        if (g < 0)
            g = -g;
        return (g > PIX_MAX) ? PIX_MAX : pix_t'(g);
    endfunction

    // True when this pixel would produce a result built from a line store entry never written.
    function automatic bit hits_unwritten(bit fs);
        int unsigned w;
        int unsigned c;
        int unsigned rows;
        w = active_width();
        c = next_col;
        rows = full_rows;
        if (fs)
        begin
            c = 0;
            rows = 0;
        end
        if (c >= w)
        begin
            c = 0;
            if (rows < ROWS_FULL)
                rows++;
        end
        if (rows < ROWS_FULL || c < 2)
            return 1'b0;
        return !(win_known[1] && win_known[2] && win_known[4] && win_known[5]
                 && upper_known[c] && middle_known[c]);
    endfunction

    task automatic predict_edge(pix_t pix, bit fs);
        int unsigned  w;
        int unsigned  c;
        int           top;
        int           bottom;
        int           left;
        int           right;
        int           sum;
        edge_result_t res;
        w = active_width();
        if (fs)
        begin
            next_col = 0;
            full_rows = 0;
        end
        // A width cut below the current column starts a new row.
        if (next_col >= w)
        begin
            next_col = 0;
            shrink_wraps++;
            if (full_rows < ROWS_FULL)
                full_rows++;
        end
        c = next_col;

        win[0] = win[1]; win[1] = win[2];
        win[3] = win[4]; win[4] = win[5];
        win[6] = win[7]; win[7] = win[8];
        win_known[0] = win_known[1]; win_known[1] = win_known[2];
        win_known[3] = win_known[4]; win_known[4] = win_known[5];
        win[2] = upper_row[c];
        win_known[2] = upper_known[c];
        win[5] = middle_row[c];
        win_known[5] = middle_known[c];
        win[8] = pix;
        upper_row[c] = middle_row[c];
        upper_known[c] = middle_known[c];
        middle_row[c] = pix;
        middle_known[c] = 1'b1;

        if (full_rows >= ROWS_FULL && c >= 2)
        begin
            top    = win[0] + win[1] + win[2];
            bottom = win[6] + win[7] + win[8];
            left   = win[0] + win[3] + win[6];
            right  = win[2] + win[5] + win[8];
            res.row_grad = clip_abs(bottom - top);
            res.col_grad = clip_abs(right - left);
            sum = int'(res.row_grad) + int'(res.col_grad);
            res.mag = (sum > PIX_MAX) ? PIX_MAX : pix_t'(sum);
            res.row_end = (c == w - 1);
            expected_edges.push_back(res);
            if (res.row_end)
                row_end_count++;
            if (w == MAX_WIDTH)
                wide_results++;
        end

        if (c + 1 >= w)
        begin
            next_col = 0;
            if (full_rows < ROWS_FULL)
                full_rows++;
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    task automatic queue_pixel(pix_t pix, bit fs);
        // Restarting the frame keeps unwritten line store entries out of every result.
        if (hits_unwritten(fs))
            fs = 1'b1;
        predict_edge(pix, fs);
        pixel_queue.push_back('{pixel: pix, frame_start: fs});
        queued_count++;
    endtask

    task automatic queue_random_pixel();
        int unsigned w;
        bit          fs;
        pix_t        pix;
        w = active_width();
        fs = 1'b0;
        if (next_col == 0 || next_col >= w)
        begin
            if (frame_rows >= rows_goal && $urandom_range(99) < 85)
                fs = 1'b1;
            else
                frame_rows++;
        end
        // Occasional broken frame on narrow images; wide frames are too costly to cut short.
        if (w < 256 && $urandom_range(149) == 0)
            fs = 1'b1;
        if (fs)
        begin
            frame_rows = 1;
            rows_goal = (w < 256) ? $urandom_range(6, 3) : 3;
            style = $urandom_range(2);
            level = $urandom_range(255);
        end
        case (style)
            0: pix = pix_t'($urandom_range(255));
            1:
            begin
                if ($urandom_range(3) == 0)
                    pix = pix_t'($urandom_range(255));
                else
                    pix = $urandom_range(1) ? PIX_MAX : '0;
            end
            default:
            begin
                level = level + int'($urandom_range(8)) - 4;
                if (level < 0)
                    level = 0;
                if (level > PIX_MAX)
                    level = PIX_MAX;
                pix = pix_t'(level);
            end
        endcase
        queue_pixel(pix, fs);
    endtask

    task automatic wait_for_idle(int settle);
        while (accepted_count != queued_count || expected_edges.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_width <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        width_setting = value;
        config_writes++;
    endtask

    // stop_col keeps the stream going until it sits that far into a row.
    task automatic run_phase(logic [WIDTH_W-1:0] value, int count, int unsigned stop_col,
                             int send_pct, int recv_pct);
        wait_for_idle(DRAIN_CYCLES);
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        write_width(value);
        for (int i = 0; i < count; i++)
            queue_random_pixel();
        while (next_col < stop_col)
            queue_random_pixel();
    endtask

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Pixel request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                accepted_count++;
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_req = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    pixel <= next_req.pixel;
                    frame_start <= next_req.frame_start;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_edges.size() == 0)
            begin
                failures++;
                $error("result with none pending: row_gradient %0d column_gradient %0d",
                       row_gradient, column_gradient);
            end
            else
            begin
                oldest_edge = expected_edges.pop_front();
                results_checked++;
                compare_field("row_gradient", oldest_edge.row_grad, row_gradient);
                compare_field("column_gradient", oldest_edge.col_grad, column_gradient);
                compare_field("magnitude", oldest_edge.mag, magnitude);
                compare_field("row_end", {7'd0, oldest_edge.row_end}, {7'd0, row_end});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_edges.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        pix_t seq_pix [26];
        seq_pix = '{0, 0, 0, 0, 0, 0, 255, 255, 255, 255, 0, 0, 0, 128, 255,
                    200, 7, 1, 2, 3, 250, 251, 252, 0, 0, 0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Narrowest image: a stream that starts without a frame marker, flat and saturating
        // rows, a falling edge, then a new frame that is itself restarted mid-row.
        write_width(WIDTH_MIN);
        for (int k = 0; k < 26; k++)
            queue_pixel(seq_pix[k], k == 15 || k == 17);

        run_phase(0,         150, 0,   IDLE_LIGHT, IDLE_HEAVY);
        run_phase(11,        180, 0,   IDLE_LIGHT, IDLE_HEAVY);
        run_phase(17,        200, 9,   IDLE_LIGHT, IDLE_HEAVY);
        run_phase(5,         150, 0,   IDLE_HEAVY, IDLE_LIGHT);
        run_phase(64,        350, 0,   IDLE_HEAVY, IDLE_LIGHT);
        run_phase(2047,      200, 0,   IDLE_HEAVY, IDLE_LIGHT);
        run_phase(WIDTH_MAX, 100, 400, IDLE_NONE,  IDLE_NONE);
        run_phase(300,       200, 0,   IDLE_NONE,  IDLE_NONE);
        run_phase(2,         150, 0,   IDLE_NONE,  IDLE_NONE);

        wait_for_idle(END_SETTLE);
        $display("Checked %0d results (%0d row ends, %0d at full width) from %0d pixels.",
                 results_checked, row_end_count, wide_results, accepted_count);
        $display("Width written %0d times, out-of-range values included; %0d rows cut short.",
                 config_writes, shrink_wraps);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ prewitt_edge_magnitude.f @@
rtl/pem_pkg.sv
rtl/pem_scan.sv
rtl/pem_window.sv
rtl/pem_gradient.sv
rtl/prewitt_edge_magnitude.sv
tb/prewitt_edge_magnitude_tb.sv
